/* rtl/core/skl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skl_pkg: shared types and constants for the k-th largest selector
// Value and count widths, the row size, and the structs passed between the
// top level, the cell row and each cell.
// ----------------------------------------------------------------------------
package skl_pkg;

   // row size and widths
   localparam int CAPACITY = 1024;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int RANK_W   = 11;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [COUNT_W-1:0]        count_type;
   typedef logic [RANK_W-1:0]         rank_type;

   // operation broadcast to every cell
   typedef struct packed {
      logic      ins;   // insert key, count grows by one
      logic      rep;   // drop the minimum, insert key
      value_type key;
   } cell_cmd_type;

   // what one cell shows its neighbors
   typedef struct packed {
      value_type val;
      logic      ge;    // holds a value above key, or is empty
      logic      lt;    // holds a value below key
   } cell_link_type;

endpackage

/* rtl/core/skl_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skl_cell: one slot of the sorted row
// Holds one value. On an insert it shifts up toward the tail, on a replace it
// shifts down toward the head, and the slot at the split point takes the key.
// ----------------------------------------------------------------------------
module skl_cell
   import skl_pkg::*;
(
   input  logic          clock,
   input  cell_cmd_type  cmd,
   input  logic          occupied,
   input  cell_link_type link_lower,
   input  cell_link_type link_upper,
   output cell_link_type link_out,
   output value_type     val_next
);

   value_type val_ff;
   value_type val_in;
   logic      ge;
   logic      lt;

   // compare against the broadcast key; empty slots sort above everything
   assign ge = !occupied || ($signed(val_ff) > $signed(cmd.key));
   assign lt = occupied && ($signed(val_ff) < $signed(cmd.key));

   // next value from the neighbor, the key, or hold
   always_comb begin
      val_in = val_ff;
      if (cmd.ins) begin
         if (link_lower.ge) begin
            val_in = link_lower.val;
         end else if (ge) begin
            val_in = cmd.key;
         end
      end else if (cmd.rep) begin
         if (link_upper.lt) begin
            val_in = link_upper.val;
         end else if (lt) begin
            val_in = cmd.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign link_out.val = val_ff;
   assign link_out.ge  = ge;
   assign link_out.lt  = lt;
   assign val_next     = val_in;

endmodule

/* rtl/core/skl_chain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skl_chain: row of cells kept in ascending order
// Slot 0 holds the smallest kept value. Slots at or above the count are
// empty; their contents are never shown.
// ----------------------------------------------------------------------------
module skl_chain
   import skl_pkg::*;
(
   input  logic         clock,
   input  cell_cmd_type cmd,
   input  count_type    count,
   output value_type    root,
   output value_type    root_next
);

   cell_link_type links [CAPACITY];
   value_type     nexts [CAPACITY];
   logic          occ   [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_link_type lower;
      cell_link_type upper;

      assign occ[i] = (count > COUNT_W'(i));

      // ends of the row see an inactive neighbor
      if (i == 0) begin : g_head
         assign lower = '0;
      end else begin : g_lower
         assign lower = links[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign upper = '0;
      end else begin : g_upper
         assign upper = links[i+1];
      end

      skl_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (occ[i]),
         .link_lower (lower),
         .link_upper (upper),
         .link_out   (links[i]),
         .val_next   (nexts[i])
      );
   end

   assign root      = links[0].val;
   assign root_next = nexts[0];

endmodule

/* rtl/core/streaming_kth_largest_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// streaming_kth_largest_select: k-th largest value of a stream of sets
// Each req_ item is a signed value; req_is_final closes a set. The block
// keeps the k largest values of the current set in a sorted row of cells and,
// on the final item, returns the smallest of them on the rsp_ channel.
//
// Usage:
//  - csr_ writes k (rank_k); zero acts as 1, values above the row size act as
//    the row size. Write only while the block is idle. csr_ready is always 1.
//  - Throughput: one item per cycle while req_ready is high. Every item is
//    resolved by a key compare broadcast to all cells and a one-slot shift.
//  - A final item that is taken is registered in the input stage, and its
//    result then in the result register, which raises rsp_valid.
//  - A set with fewer than k values returns zero with rsp_too_few set.
//  - When rsp_ stalls, non-final items keep flowing; a final item waits in
//    the input stage until the held result is taken, and req_ready stays low.
//  - Reset empties the row at once (count cleared, no sweep) and sets k to 1.
// ----------------------------------------------------------------------------
module streaming_kth_largest_select
   import skl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  value_type req_sample_value,
   input  logic      req_is_final,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output value_type rsp_kth_value,
   output logic      rsp_too_few,
   input  logic      csr_valid,
   output logic      csr_ready,
   input  rank_type  csr_rank_k
);

   rank_type     rank_ff;
   count_type    count_ff, count_in;
   logic         stage_v_ff;
   value_type    stage_key_ff;
   logic         stage_final_ff;
   logic         rsp_valid_ff;
   value_type    rsp_value_ff;
   logic         rsp_few_ff;

   logic         stage_go;
   logic         room;
   cell_cmd_type cmd;
   value_type    root, root_next;
   count_type    count_after;
   logic         few;

   // rank register, stored already clamped
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= RANK_W'(1);
      end else if (csr_valid) begin
         if (csr_rank_k == '0) begin
            rank_ff <= RANK_W'(1);
         end else if (csr_rank_k > RANK_W'(CAPACITY)) begin
            rank_ff <= RANK_W'(CAPACITY);
         end else begin
            rank_ff <= csr_rank_k;
         end
      end
   end

   // input stage advances unless a final item finds the output full
   assign stage_go  = stage_v_ff && (!stage_final_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_v_ff || stage_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= 1'b0;
      end else if (req_ready) begin
         stage_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         stage_key_ff   <= req_sample_value;
         stage_final_ff <= req_is_final;
      end
   end

   // operation on the row
   assign room    = (COUNT_W'(rank_ff) > count_ff);
   assign cmd.key = stage_key_ff;
   assign cmd.ins = stage_go && room;
   assign cmd.rep = stage_go && !room && (count_ff != '0)
                    && ($signed(stage_key_ff) > $signed(root));

   skl_chain u_chain (
      .clock     (clock),
      .cmd       (cmd),
      .count     (count_ff),
      .root      (root),
      .root_next (root_next)
   );

   // fill count; a final item empties the row
   assign count_after = count_ff + COUNT_W'(cmd.ins);
   assign few         = (COUNT_W'(rank_ff) > count_after);

   always_comb begin
      count_in = count_ff;
      if (stage_go) begin
         count_in = stage_final_ff ? '0 : count_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_go && stage_final_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_go && stage_final_ff) begin
         rsp_value_ff <= few ? '0 : root_next;
         rsp_few_ff   <= few;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kth_value = rsp_value_ff;
   assign rsp_too_few   = rsp_few_ff;

endmodule

/* rtl/core/skl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skl_checker: port-level checks for the k-th largest selector
// Watches the top level's ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module skl_checker
   import skl_pkg::*;
(
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input logic      req_is_final,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input value_type rsp_kth_value,
   input logic      rsp_too_few
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kth_value)
                                  && $stable(rsp_too_few))
      else $error("rsp item changed while stalled");

   // a short set reports zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_few |-> rsp_kth_value == '0)
      else $error("too_few result with nonzero value");

   // a new result follows a final item that was taken
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_is_final, 2))
      else $error("result without a final item");

   // no result straight out of reset
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind streaming_kth_largest_select skl_checker u_skl_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_is_final  (req_is_final),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_kth_value (rsp_kth_value),
   .rsp_too_few   (rsp_too_few)
);
